// ===== src/lnle_pkg.sv =====
`default_nettype none
package lnle_pkg;

  localparam int POS_W       = 32;
  localparam int BOX_W       = 31;
  localparam int CUT_W       = 32;
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int ENERGY_W    = 48;
  localparam int COUNT_OUT_W = 12;
  localparam int WRAP_OUT_W  = 4;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_X  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_Y  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_Z  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF = 2'd3;

  // periodic image shift select per axis
  localparam logic [1:0] SHIFT_NEG  = 2'd0;
  localparam logic [1:0] SHIFT_NONE = 2'd1;
  localparam logic [1:0] SHIFT_POS  = 2'd2;

  typedef enum logic [1:0] {
    CMD_BUILD = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_BAD   = 2'd3
  } cmd_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_WSUB,
    OP_WCHK_HI,
    OP_WADD,
    OP_WCHK_LO,
    OP_IMG_DIFF,
    OP_IMG_TEST,
    OP_EN_DIFF,
    OP_SKIP,
    OP_DIV_START,
    OP_Q_LOAD,
    OP_MQ_R4,
    OP_MQ_R6,
    OP_MQ_R12,
    OP_FIN,
    OP_RESULT
  } op_e;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_SQ0,
    MUL_SQ1,
    MUL_SQ2,
    MUL_P0,
    MUL_P1,
    MUL_P2,
    MUL_P3
  } mul_e;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_SQ,
    ACC_P0,
    ACC_MID,
    ACC_P3
  } acc_e;

  typedef struct packed {
    op_e        op;
    mul_e       mul;
    acc_e       acc;
    logic [1:0] ix;
    logic [1:0] iy;
    logic [1:0] iz;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic list_end;
    logic far;
    logic div_valid;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== src/lnle_div.sv =====
`default_nettype none
module lnle_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] den,
  output logic        valid,
  output logic [63:0] quot
);
  // restoring division of 2^64 by den, one quotient bit a cycle
  localparam int QBITS = 65;

  logic [63:0] den_r;
  logic [63:0] rem_r;
  logic [QBITS-1:0] quo_r;
  logic [6:0] step_r;
  logic busy_r;
  logic valid_r;

  logic [64:0] rem_sh;
  logic [64:0] rem_sub;
  logic ge;

  assign rem_sh  = {rem_r, (step_r == 7'(QBITS - 1))};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
    end else if (start) begin
      busy_r  <= 1'b1;
      valid_r <= 1'b0;
    end else if (busy_r && step_r == 7'd0) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r  <= den;
      rem_r  <= '0;
      quo_r  <= '0;
      step_r <= 7'(QBITS - 1);
    end else if (busy_r) begin
      rem_r  <= ge ? rem_sub[63:0] : rem_sh[63:0];
      quo_r  <= {quo_r[QBITS-2:0], ge};
      step_r <= step_r - 7'd1;
    end
  end

  // a quotient of 2^64 or more (divisor zero or one) saturates
  assign quot  = quo_r[QBITS-1] ? '1 : quo_r[63:0];
  assign valid = valid_r;

endmodule
`default_nettype wire

// ===== src/lnle_dp.sv =====
`default_nettype none
module lnle_dp #(
  parameter int LIST_DEPTH = 2048,
  parameter int MAX_WRAPS  = 7
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [lnle_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lnle_pkg::CFG_W-1:0]            cfg_data,
  input  logic [1:0]                            in_cmd,
  input  logic signed [lnle_pkg::POS_W-1:0]     in_pos_x,
  input  logic signed [lnle_pkg::POS_W-1:0]     in_pos_y,
  input  logic signed [lnle_pkg::POS_W-1:0]     in_pos_z,
  input  lnle_pkg::dp_cmd_t                     cmd,
  output lnle_pkg::dp_stat_t                    st,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [1:0]                            out_kind,
  output logic signed [lnle_pkg::POS_W-1:0]     out_center_x,
  output logic signed [lnle_pkg::POS_W-1:0]     out_center_y,
  output logic signed [lnle_pkg::POS_W-1:0]     out_center_z,
  output logic signed [lnle_pkg::WRAP_OUT_W-1:0] out_wraps_x,
  output logic signed [lnle_pkg::WRAP_OUT_W-1:0] out_wraps_y,
  output logic signed [lnle_pkg::WRAP_OUT_W-1:0] out_wraps_z,
  output logic signed [lnle_pkg::ENERGY_W-1:0]  out_energy,
  output logic [lnle_pkg::COUNT_OUT_W-1:0]      out_list_count,
  output logic                                  out_error_flag
);
  import lnle_pkg::*;

  localparam int AW  = $clog2(LIST_DEPTH);
  localparam int CW  = $clog2(LIST_DEPTH + 1);
  localparam int WCW = $clog2(MAX_WRAPS + 1) + 1;
  localparam logic signed [50:0] E_MAX = 51'sd140737488355327;
  localparam logic signed [50:0] E_MIN = -51'sd140737488355328;

  // configuration
  logic [BOX_W-1:0] box_r [3];
  logic [CUT_W-1:0] cutoff_r;

  // item and list state
  cmd_e cmd_r;
  logic signed [POS_W-1:0] pos_r [3];
  logic signed [33:0] t_r [3];
  logic signed [WCW-1:0] w_r [3];
  logic err_r;
  logic [POS_W-1:0] center_r [3];
  logic [CW-1:0] count_r;
  logic [CW-1:0] rd_idx_r;

  // arithmetic registers
  logic [31:0] img_r [3];
  logic [31:0] dd_r [3];
  logic far_r;
  logic [63:0] s_r;
  logic [63:0] prod_r;
  logic [127:0] acc_r;
  logic [63:0] opa_r, opb_r, q_r, r6_r;
  logic [63:0] s12_r, s6_r;
  logic sat_r;
  logic signed [64:0] diff_r;

  // neighbor memory
  logic [31:0] mem_x [LIST_DEPTH];
  logic [31:0] mem_y [LIST_DEPTH];
  logic [31:0] mem_z [LIST_DEPTH];
  logic [31:0] rd_r [3];

  logic out_valid_r;

  // combinational helpers
  logic signed [33:0] box34 [3], pos34 [3], ctr34 [3], img_c [3];
  logic signed [34:0] idif [3];
  logic [34:0] iabs [3];
  logic signed [32:0] edif [3];
  logic [32:0] eabs [3];
  logic [1:0] shsel [3];
  logic ifar, efar, hi_any, lo_any, img_pass, list_full;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod_c;
  logic [63:0] mq_sat;
  logic [64:0] s12_sum, s6_sum;
  logic signed [64:0] dsh;
  logic signed [50:0] esh;
  logic signed [ENERGY_W-1:0] e_val;
  logic e_err;
  logic [63:0] div_q;
  logic div_valid;

  always_comb begin
    shsel[0] = cmd.ix;
    shsel[1] = cmd.iy;
    shsel[2] = cmd.iz;
    ifar   = 1'b0;
    efar   = 1'b0;
    hi_any = 1'b0;
    lo_any = 1'b0;
    for (int a = 0; a < 3; a++) begin
      box34[a] = 34'(box_r[a]);
      pos34[a] = 34'(pos_r[a]);
      ctr34[a] = 34'($signed(center_r[a]));
      case (shsel[a])
        SHIFT_NEG: img_c[a] = pos34[a] - box34[a];
        SHIFT_POS: img_c[a] = pos34[a] + box34[a];
        default:   img_c[a] = pos34[a];
      endcase
      idif[a] = 35'(img_c[a]) - 35'(ctr34[a]);
      iabs[a] = idif[a][34] ? 35'(-idif[a]) : 35'(idif[a]);
      edif[a] = 33'($signed(rd_r[a])) - 33'(pos_r[a]);
      eabs[a] = edif[a][32] ? 33'(-edif[a]) : 33'(edif[a]);
      ifar    = ifar | (|iabs[a][34:24]);
      efar    = efar | (|eabs[a][32:31]);
      hi_any  = hi_any | (t_r[a] > box34[a]);
      lo_any  = lo_any | t_r[a][33];
    end
  end

  assign img_pass  = !far_r && (s_r < {16'b0, cutoff_r, 16'b0});
  assign list_full = count_r == CW'(LIST_DEPTH);

  // shared 32x32 multiplier
  always_comb begin
    case (cmd.mul)
      MUL_SQ0: begin mul_a = dd_r[0];       mul_b = dd_r[0];       end
      MUL_SQ1: begin mul_a = dd_r[1];       mul_b = dd_r[1];       end
      MUL_SQ2: begin mul_a = dd_r[2];       mul_b = dd_r[2];       end
      MUL_P0:  begin mul_a = opa_r[31:0];   mul_b = opb_r[31:0];   end
      MUL_P1:  begin mul_a = opa_r[31:0];   mul_b = opb_r[63:32];  end
      MUL_P2:  begin mul_a = opa_r[63:32];  mul_b = opb_r[31:0];   end
      MUL_P3:  begin mul_a = opa_r[63:32];  mul_b = opb_r[63:32];  end
      default: begin mul_a = '0;            mul_b = '0;            end
    endcase
  end
  assign prod_c = mul_a * mul_b;

  assign mq_sat  = (acc_r[127:96] != '0) ? '1 : acc_r[95:32];
  assign s12_sum = {1'b0, s12_r} + {1'b0, mq_sat};
  assign s6_sum  = {1'b0, s6_r} + {1'b0, r6_r};

  // floor((sum12 - sum6) / 2^14), clamped
  assign dsh = diff_r >>> 14;
  assign esh = dsh[50:0];
  always_comb begin
    e_err = 1'b1;
    if (sat_r) begin
      e_val = E_MAX[ENERGY_W-1:0];
    end else if (esh > E_MAX) begin
      e_val = E_MAX[ENERGY_W-1:0];
    end else if (esh < E_MIN) begin
      e_val = E_MIN[ENERGY_W-1:0];
    end else begin
      e_val = esh[ENERGY_W-1:0];
      e_err = 1'b0;
    end
  end

  lnle_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.op == OP_DIV_START),
    .den   (s_r),
    .valid (div_valid),
    .quot  (div_q)
  );

  // configuration, list control and result handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r[0]    <= 31'd393216;
      box_r[1]    <= 31'd393216;
      box_r[2]    <= 31'd393216;
      cutoff_r    <= 32'd6553600;
      count_r     <= '0;
      center_r[0] <= '0;
      center_r[1] <= '0;
      center_r[2] <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BOX_X:  box_r[0] <= cfg_data[BOX_W-1:0];
          CFG_BOX_Y:  box_r[1] <= cfg_data[BOX_W-1:0];
          CFG_BOX_Z:  box_r[2] <= cfg_data[BOX_W-1:0];
          CFG_CUTOFF: cutoff_r <= cfg_data[CUT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_WCHK_LO) begin
        for (int a = 0; a < 3; a++) center_r[a] <= t_r[a][31:0];
        count_r <= '0;
      end
      if (cmd.op == OP_IMG_TEST && img_pass && !list_full) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.op == OP_RESULT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_IMG_TEST && img_pass && !list_full) begin
      mem_x[count_r[AW-1:0]] <= img_r[0];
      mem_y[count_r[AW-1:0]] <= img_r[1];
      mem_z[count_r[AW-1:0]] <= img_r[2];
    end
    rd_r[0] <= mem_x[rd_idx_r[AW-1:0]];
    rd_r[1] <= mem_y[rd_idx_r[AW-1:0]];
    rd_r[2] <= mem_z[rd_idx_r[AW-1:0]];
  end

  // item datapath
  always_ff @(posedge clk) begin
    if (cmd.mul != MUL_NONE) prod_r <= prod_c;
    case (cmd.acc)
      ACC_SQ:  s_r   <= s_r + prod_r;
      ACC_P0:  acc_r <= {64'b0, prod_r};
      ACC_MID: acc_r <= acc_r + {32'b0, prod_r, 32'b0};
      ACC_P3:  acc_r <= acc_r + {prod_r, 64'b0};
      default: ;
    endcase
    case (cmd.op)
      OP_LOAD: begin
        cmd_r    <= cmd_e'(in_cmd);
        pos_r[0] <= in_pos_x;
        pos_r[1] <= in_pos_y;
        pos_r[2] <= in_pos_z;
        t_r[0]   <= 34'(in_pos_x);
        t_r[1]   <= 34'(in_pos_y);
        t_r[2]   <= 34'(in_pos_z);
        for (int a = 0; a < 3; a++) w_r[a] <= '0;
        err_r    <= (in_cmd == CMD_BAD);
        rd_idx_r <= '0;
        s12_r    <= '0;
        s6_r     <= '0;
        sat_r    <= 1'b0;
      end
      OP_WSUB: begin
        for (int a = 0; a < 3; a++) begin
          if (t_r[a] > box34[a]) begin
            t_r[a] <= t_r[a] - box34[a];
            w_r[a] <= w_r[a] + WCW'(1);
          end
        end
      end
      OP_WCHK_HI: begin
        if (hi_any) err_r <= 1'b1;
      end
      OP_WADD: begin
        for (int a = 0; a < 3; a++) begin
          if (t_r[a][33]) begin
            t_r[a] <= t_r[a] + box34[a];
            w_r[a] <= w_r[a] - WCW'(1);
          end
        end
      end
      OP_WCHK_LO: begin
        if (lo_any) err_r <= 1'b1;
      end
      OP_IMG_DIFF: begin
        for (int a = 0; a < 3; a++) begin
          img_r[a] <= img_c[a][31:0];
          dd_r[a]  <= iabs[a][31:0];
        end
        far_r <= ifar;
        s_r   <= '0;
      end
      OP_IMG_TEST: begin
        if (img_pass && list_full) err_r <= 1'b1;
      end
      OP_EN_DIFF: begin
        for (int a = 0; a < 3; a++) dd_r[a] <= eabs[a][31:0];
        far_r <= efar;
        s_r   <= '0;
      end
      OP_SKIP: begin
        rd_idx_r <= rd_idx_r + CW'(1);
      end
      OP_Q_LOAD: begin
        q_r   <= div_q;
        opa_r <= div_q;
        opb_r <= div_q;
      end
      OP_MQ_R4: begin
        opa_r <= mq_sat;
        opb_r <= q_r;
      end
      OP_MQ_R6: begin
        r6_r  <= mq_sat;
        opa_r <= mq_sat;
        opb_r <= mq_sat;
      end
      OP_MQ_R12: begin
        s12_r    <= s12_sum[64] ? '1 : s12_sum[63:0];
        s6_r     <= s6_sum[64] ? '1 : s6_sum[63:0];
        if (s12_sum[64] || s6_sum[64]) sat_r <= 1'b1;
        rd_idx_r <= rd_idx_r + CW'(1);
      end
      OP_FIN: begin
        diff_r <= $signed({1'b0, s12_r}) - $signed({1'b0, s6_r});
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.op == OP_RESULT) begin
      out_kind       <= cmd_r;
      out_center_x   <= center_r[0];
      out_center_y   <= center_r[1];
      out_center_z   <= center_r[2];
      out_wraps_x    <= (cmd_r == CMD_BUILD) ? WRAP_OUT_W'(w_r[0]) : '0;
      out_wraps_y    <= (cmd_r == CMD_BUILD) ? WRAP_OUT_W'(w_r[1]) : '0;
      out_wraps_z    <= (cmd_r == CMD_BUILD) ? WRAP_OUT_W'(w_r[2]) : '0;
      out_energy     <= (cmd_r == CMD_QUERY) ? e_val : '0;
      out_list_count <= COUNT_OUT_W'(count_r);
      out_error_flag <= err_r | ((cmd_r == CMD_QUERY) & e_err);
    end
  end

  assign out_valid    = out_valid_r;
  assign st.cmd       = cmd_r;
  assign st.list_end  = rd_idx_r >= count_r;
  assign st.far       = far_r;
  assign st.div_valid = div_valid;
  assign st.out_free  = !out_valid_r || out_ready;

`ifndef SYNTHESIS
  a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_RESULT |-> (!out_valid_r || out_ready))
    else $error("result written over an item not yet taken");
  a_full_list_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_IMG_TEST && list_full) |=> $stable(count_r))
    else $error("neighbor count moved past a full list");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(LIST_DEPTH))
    else $error("neighbor count beyond list depth");
`endif

endmodule
`default_nettype wire

// ===== src/lnle_ctrl.sv =====
`default_nettype none
module lnle_ctrl #(
  parameter int MAX_WRAPS = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lnle_pkg::dp_stat_t st,
  output lnle_pkg::dp_cmd_t  cmd
);
  import lnle_pkg::*;

  localparam int WSW = $clog2(MAX_WRAPS + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH,
    S_WSUB, S_WCHK_HI, S_WADD, S_WCHK_LO,
    S_IMG_DIFF, S_SQ0, S_SQ1, S_SQ2, S_SQ3, S_IMG_TEST,
    S_EN_CHECK, S_EN_DIFF, S_EN_FARCHK, S_DIV_WAIT,
    S_M0, S_M1, S_M2, S_M3, S_M4, S_MQ_END,
    S_FIN, S_DONE
  } state_t;

  typedef enum logic [1:0] {PH_R4, PH_R6, PH_R12} phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic [WSW-1:0] wcnt_r, wcnt_nxt;
  logic [1:0] ix_r, iy_r, iz_r, ix_nxt, iy_nxt, iz_nxt;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    wcnt_nxt  = wcnt_r;
    ix_nxt    = ix_r;
    iy_nxt    = iy_r;
    iz_nxt    = iz_r;
    cmd.op    = OP_NONE;
    cmd.mul   = MUL_NONE;
    cmd.acc   = ACC_NONE;
    cmd.ix    = ix_r;
    cmd.iy    = iy_r;
    cmd.iz    = iz_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          wcnt_nxt  = '0;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (st.cmd)
          CMD_BUILD: state_nxt = S_WSUB;
          CMD_ADD: begin
            ix_nxt    = SHIFT_NEG;
            iy_nxt    = SHIFT_NEG;
            iz_nxt    = SHIFT_NEG;
            state_nxt = S_IMG_DIFF;
          end
          CMD_QUERY: state_nxt = S_EN_CHECK;
          default:   state_nxt = S_DONE;
        endcase
      end
      S_WSUB: begin
        cmd.op = OP_WSUB;
        if (wcnt_r == WSW'(MAX_WRAPS - 1)) begin
          wcnt_nxt  = '0;
          state_nxt = S_WCHK_HI;
        end else begin
          wcnt_nxt = wcnt_r + WSW'(1);
        end
      end
      S_WCHK_HI: begin
        cmd.op    = OP_WCHK_HI;
        state_nxt = S_WADD;
      end
      S_WADD: begin
        cmd.op = OP_WADD;
        if (wcnt_r == WSW'(MAX_WRAPS - 1)) begin
          wcnt_nxt  = '0;
          state_nxt = S_WCHK_LO;
        end else begin
          wcnt_nxt = wcnt_r + WSW'(1);
        end
      end
      S_WCHK_LO: begin
        cmd.op    = OP_WCHK_LO;
        state_nxt = S_DONE;
      end
      S_IMG_DIFF: begin
        cmd.op    = OP_IMG_DIFF;
        state_nxt = S_SQ0;
      end
      S_SQ0: begin
        cmd.mul   = MUL_SQ0;
        state_nxt = S_SQ1;
      end
      S_SQ1: begin
        cmd.mul   = MUL_SQ1;
        cmd.acc   = ACC_SQ;
        state_nxt = S_SQ2;
      end
      S_SQ2: begin
        cmd.mul   = MUL_SQ2;
        cmd.acc   = ACC_SQ;
        state_nxt = S_SQ3;
      end
      S_SQ3: begin
        cmd.acc   = ACC_SQ;
        state_nxt = (st.cmd == CMD_ADD) ? S_IMG_TEST : S_EN_FARCHK;
      end
      S_IMG_TEST: begin
        cmd.op    = OP_IMG_TEST;
        state_nxt = S_IMG_DIFF;
        if (iz_r != SHIFT_POS) begin
          iz_nxt = iz_r + 2'd1;
        end else begin
          iz_nxt = SHIFT_NEG;
          if (iy_r != SHIFT_POS) begin
            iy_nxt = iy_r + 2'd1;
          end else begin
            iy_nxt = SHIFT_NEG;
            if (ix_r != SHIFT_POS) begin
              ix_nxt = ix_r + 2'd1;
            end else begin
              state_nxt = S_DONE;
            end
          end
        end
      end
      S_EN_CHECK: begin
        state_nxt = st.list_end ? S_FIN : S_EN_DIFF;
      end
      S_EN_DIFF: begin
        cmd.op    = OP_EN_DIFF;
        state_nxt = S_SQ0;
      end
      S_EN_FARCHK: begin
        if (st.far) begin
          cmd.op    = OP_SKIP;
          state_nxt = S_EN_CHECK;
        end else begin
          cmd.op    = OP_DIV_START;
          state_nxt = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (st.div_valid) begin
          cmd.op    = OP_Q_LOAD;
          phase_nxt = PH_R4;
          state_nxt = S_M0;
        end
      end
      S_M0: begin
        cmd.mul   = MUL_P0;
        state_nxt = S_M1;
      end
      S_M1: begin
        cmd.mul   = MUL_P1;
        cmd.acc   = ACC_P0;
        state_nxt = S_M2;
      end
      S_M2: begin
        cmd.mul   = MUL_P2;
        cmd.acc   = ACC_MID;
        state_nxt = S_M3;
      end
      S_M3: begin
        cmd.mul   = MUL_P3;
        cmd.acc   = ACC_MID;
        state_nxt = S_M4;
      end
      S_M4: begin
        cmd.acc   = ACC_P3;
        state_nxt = S_MQ_END;
      end
      S_MQ_END: begin
        case (phase_r)
          PH_R4: begin
            cmd.op    = OP_MQ_R4;
            phase_nxt = PH_R6;
            state_nxt = S_M0;
          end
          PH_R6: begin
            cmd.op    = OP_MQ_R6;
            phase_nxt = PH_R12;
            state_nxt = S_M0;
          end
          default: begin
            cmd.op    = OP_MQ_R12;
            state_nxt = S_EN_CHECK;
          end
        endcase
      end
      S_FIN: begin
        cmd.op    = OP_FIN;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.op    = OP_RESULT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_R4;
      wcnt_r  <= '0;
      ix_r    <= SHIFT_NEG;
      iy_r    <= SHIFT_NEG;
      iz_r    <= SHIFT_NEG;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      wcnt_r  <= wcnt_nxt;
      ix_r    <= ix_nxt;
      iy_r    <= iy_nxt;
      iz_r    <= iz_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/lj_neighbor_list_energy_core.sv =====
`default_nettype none
// Channel  Handshake              Payload
// in       in_valid / in_ready    in_cmd, in_pos_x, in_pos_y, in_pos_z
// out      out_valid / out_ready  out_kind, out_center_*, out_wraps_*, out_energy,
//                                 out_list_count, out_error_flag
// cfg      cfg_we (no wait)       cfg_index, cfg_data
//
// One item at a time. A build's length is set by the per-axis wrap loop, one box length
// a cycle. An add visits all 27 periodic images, each through the shared 32x32
// multiplier. A query's time per stored entry is set by the 65-step divider and
// three four-pass 64-bit products on the one multiplier; a far entry skips both.
// Reset (rst_n low, synchronous) clears the list count and the center, loads the
// default box lengths and cutoff, and resets the controller; no memory clearing
// pass is needed. A new item is accepted once the previous one has reached the
// output register, even while that result still waits for out_ready.
module lj_neighbor_list_energy_core #(
  parameter int LIST_DEPTH = 2048,
  parameter int MAX_WRAPS  = 7
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [lnle_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [lnle_pkg::CFG_W-1:0]             cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [1:0]                             in_cmd,
  input  logic signed [lnle_pkg::POS_W-1:0]      in_pos_x,
  input  logic signed [lnle_pkg::POS_W-1:0]      in_pos_y,
  input  logic signed [lnle_pkg::POS_W-1:0]      in_pos_z,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [1:0]                             out_kind,
  output logic signed [lnle_pkg::POS_W-1:0]      out_center_x,
  output logic signed [lnle_pkg::POS_W-1:0]      out_center_y,
  output logic signed [lnle_pkg::POS_W-1:0]      out_center_z,
  output logic signed [lnle_pkg::WRAP_OUT_W-1:0] out_wraps_x,
  output logic signed [lnle_pkg::WRAP_OUT_W-1:0] out_wraps_y,
  output logic signed [lnle_pkg::WRAP_OUT_W-1:0] out_wraps_z,
  output logic signed [lnle_pkg::ENERGY_W-1:0]   out_energy,
  output logic [lnle_pkg::COUNT_OUT_W-1:0]       out_list_count,
  output logic                                   out_error_flag
);
  import lnle_pkg::*;

  // controller drives one command a cycle; datapath reports back
  dp_cmd_t  cmd;
  dp_stat_t st;

  lnle_ctrl #(
    .MAX_WRAPS (MAX_WRAPS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // datapath holds the configuration, list memory, multiplier, divider
  // and the result register
  lnle_dp #(
    .LIST_DEPTH (LIST_DEPTH),
    .MAX_WRAPS  (MAX_WRAPS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_cmd         (in_cmd),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pos_z       (in_pos_z),
    .cmd            (cmd),
    .st             (st),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_center_x   (out_center_x),
    .out_center_y   (out_center_y),
    .out_center_z   (out_center_z),
    .out_wraps_x    (out_wraps_x),
    .out_wraps_y    (out_wraps_y),
    .out_wraps_z    (out_wraps_z),
    .out_energy     (out_energy),
    .out_list_count (out_list_count),
    .out_error_flag (out_error_flag)
  );

endmodule
`default_nettype wire
